// ===== hw/rtl/vpo_pkg.sv =====
// Shared types, widths and constants for the vector polar octant block.
// No dependencies; every other file in hw/rtl imports this package.
package vpo_pkg;

    // Field and arithmetic widths
    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STEPS    = 16;

    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int GUARD_BITS = 16;
    localparam int PROD_W     = COORD_WIDTH + GAIN_W;
    localparam int ABS_W      = COORD_WIDTH + 1;
    localparam int SQ_W       = 2 * COORD_WIDTH;
    localparam int CX_W       = ABS_W + GUARD_BITS + 3;
    localparam int ATAN_W     = 22;
    localparam int ATAN_IDX_W = 5;
    localparam int Z_W        = ATAN_W + 3;
    localparam int T_W        = 23;
    localparam int A_W        = 25;
    localparam int ANGLE_W    = 9 + ANGLE_FRAC_BITS;
    localparam int DIR_W      = 4;
    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int CFG_IDX_W  = 2;

    // Angle constants in Q16 degrees
    localparam logic [A_W-1:0] DEG90_Q16  = A_W'(90 * 65536);
    localparam logic [A_W-1:0] DEG180_Q16 = A_W'(180 * 65536);
    localparam logic [A_W-1:0] DEG360_Q16 = A_W'(360 * 65536);

    // Output rounding and direction thresholds
    localparam int ROUND_SH   = GUARD_BITS - ANGLE_FRAC_BITS;
    localparam int ROUND_HALF = (ROUND_SH > 0) ? (1 << (ROUND_SH - 1)) : 0;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL = ANGLE_W'(360 << ANGLE_FRAC_BITS);
    localparam logic [ANGLE_W:0]   DIR_NUM    = (ANGLE_W + 1)'(675 << ANGLE_FRAC_BITS);
    localparam int                 DIR_DEN    = 90 << ANGLE_FRAC_BITS;

    // Direction codes that do not come straight from the sector count
    localparam logic [DIR_W-1:0] DIR_SECTOR_ZERO = 4'd8;
    localparam logic [DIR_W-1:0] DIR_BELOW_RANGE = 4'd7;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 2'd1;

    // Request payloads
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_in;
        logic signed [COORD_WIDTH-1:0] y_in;
    } vpo_in_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] magnitude;
        logic [ANGLE_W-1:0]     angle;
        logic [DIR_W-1:0]       direction;
        logic                   is_zero;
    } vpo_out_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_CLAMP,
        ST_START,
        ST_RUN,
        ST_PLACE,
        ST_OUT
    } vpo_state_t;

    // Arctangent of 2^-i in Q16 degrees, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/vpo_cordic.sv =====
// Iterative CORDIC vectoring unit: first-quadrant angle of (ax, ay) in Q16 degrees.
// One micro-rotation per cycle; depends on vpo_pkg.
module vpo_cordic (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [vpo_pkg::ABS_W-1:0]   ax,
    input  logic [vpo_pkg::ABS_W-1:0]   ay,
    output logic                        done,
    output logic [vpo_pkg::T_W-1:0]     t
);
    import vpo_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    logic signed [CX_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [Z_W-1:0]  z_reg, z_next, z_step;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   xzero_reg, yzero_reg;

    // Shifted cross terms and table lookup for the current step
    always_comb begin
        dx     = y_reg >>> step_reg;
        dy     = x_reg >>> step_reg;
        z_step = Z_W'(atan_q16(ATAN_IDX_W'(step_reg)));
    end

    // Micro-rotation toward y = 0 and step sequencing
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            x_next    = CX_W'({ax, {GUARD_BITS{1'b0}}});
            y_next    = CX_W'({ay, {GUARD_BITS{1'b0}}});
            z_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!y_reg[CX_W-1]) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + z_step;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - z_step;
            end
            if (step_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (start) begin
            xzero_reg <= (ax == '0);
            yzero_reg <= (ay == '0);
        end
    end

    // Axis cases are exact; otherwise clamp to 0..90 degrees
    always_comb begin
        if (yzero_reg) begin
            t = '0;
        end else if (xzero_reg) begin
            t = T_W'(DEG90_Q16);
        end else if (z_reg < 0) begin
            t = '0;
        end else if (z_reg > signed'(Z_W'(DEG90_Q16))) begin
            t = T_W'(DEG90_Q16);
        end else begin
            t = z_reg[T_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/vpo_isqrt.sv =====
// Digit-by-digit square root of ax^2 + ay^2, rounded to nearest.
// Two radicand bits per cycle; depends on vpo_pkg.
module vpo_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [vpo_pkg::ABS_W-1:0]       ax,
    input  logic [vpo_pkg::ABS_W-1:0]       ay,
    output logic                            done,
    output logic [vpo_pkg::COORD_WIDTH-1:0] root
);
    import vpo_pkg::*;

    logic [2*ABS_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [SQ_W-1:0]    n_reg, n_next, r_reg, r_next;
    logic [SQ_W-2:0]    bit_reg, bit_next;
    logic [SQ_W:0]      trial;
    logic               sqv_reg, sqv_next, run_reg, run_next;
    logic               fin_reg, fin_next, done_reg, done_next;

    // Squares, then the sum; both fit the radicand width
    always_comb begin
        sqx_full = ax * ax;
        sqy_full = ay * ay;
        trial    = {1'b0, r_reg} + (SQ_W + 1)'(bit_reg);
    end

    // Restoring root recurrence and final rounding step
    always_comb begin
        n_next    = n_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        sqv_next  = 1'b0;
        run_next  = run_reg;
        fin_next  = 1'b0;
        done_next = done_reg;
        if (start) begin
            sqv_next  = 1'b1;
            done_next = 1'b0;
        end else if (sqv_reg) begin
            n_next   = sqx_reg + sqy_reg;
            r_next   = '0;
            bit_next = {1'b1, {(SQ_W - 2){1'b0}}};
            run_next = 1'b1;
        end else if (run_reg) begin
            if ({1'b0, n_reg} >= trial) begin
                n_next = n_reg - trial[SQ_W-1:0];
                r_next = (r_reg >> 1) + SQ_W'(bit_reg);
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end else if (fin_reg) begin
            if (n_reg > r_reg) begin
                r_next = r_reg + 1'b1;
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqv_reg  <= 1'b0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            sqv_reg  <= sqv_next;
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
        if (start) begin
            sqx_reg <= sqx_full[SQ_W-1:0];
            sqy_reg <= sqy_full[SQ_W-1:0];
        end
    end

    assign done = done_reg;
    assign root = r_reg[COORD_WIDTH-1:0];

endmodule

// ===== hw/rtl/vector_polar_octant_top.sv =====
// Top level of the vector polar octant block: scaling, sequencer, output register.
// Depends on vpo_pkg, vpo_cordic and vpo_isqrt.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one motion vector (x_in, y_in)
//   per request. Result channel m_valid/m_ready/m_data returns magnitude,
//   angle (1/64 degree), direction code and is_zero, one result per request.
//   Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
//   per-axis Q8.8 gains; index 0 is scale_x, 1 is scale_y, others are ignored.
//   cfg_ready is always high; write gains only while the block is idle.
// Sequencing:
//   The radix-4 square root sets the pace of a request: one multiply stage,
//   sixteen root digits, then a rounding step, with the 16-step CORDIC
//   running alongside. A vector that scales to zero skips both units and
//   goes from the clamp state straight to the output state.
//   One request is in flight at a time; s_ready is high while the sequencer
//   idles, also while a finished result waits in the output register.
//   A stalled receiver holds the result; the next one waits behind it.
// Reset: aresetn (synchronous, active low) sets both gains to 1.0, clears the
//   held direction to 0 and empties the output register.
module vector_polar_octant_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  vpo_pkg::vpo_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output vpo_pkg::vpo_out_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vpo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vpo_pkg::GAIN_W-1:0]      cfg_data
);
    import vpo_pkg::*;

    vpo_state_t state_reg, state_next;

    logic signed [GAIN_W-1:0]      scale_x_reg, scale_x_next, scale_y_reg, scale_y_next;
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, sx_next, sy_next;
    logic signed [PROD_W-1:0]      px_reg, py_reg;
    logic signed [PROD_W-GAIN_FRAC-1:0] psx, psy;
    logic signed [COORD_WIDTH:0]   sxe, sye;
    logic [ABS_W-1:0]              ax_reg, ay_reg, ax_next, ay_next;
    logic                          sx_neg_reg, sy_neg_reg, zero_reg, zero_next;
    logic                          sy_pos;
    logic [A_W-1:0]                a_q16, a_round;
    logic [ANGLE_W-1:0]            ang_pre_reg, ang;
    logic [ANGLE_W:0]              twice, q2;
    logic [2:0]                    sector;
    logic [DIR_W-1:0]              dir_code;
    logic [DIR_W-1:0]              last_dir_reg, last_dir_next;
    logic                          m_valid_reg, m_valid_next;
    vpo_out_t                      m_data_reg, m_data_next;

    logic                          unit_start, out_load;
    logic                          cordic_done, isqrt_done;
    logic [T_W-1:0]                t;
    logic [COORD_WIDTH-1:0]        root;

    vpo_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .done    (cordic_done),
        .t       (t)
    );

    vpo_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .ax      (ax_reg),
        .ay      (ay_reg),
        .done    (isqrt_done),
        .root    (root)
    );

    // Configuration writes; unknown indexes are dropped
    always_comb begin
        scale_x_next = scale_x_reg;
        scale_y_next = scale_y_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SCALE_X: scale_x_next = cfg_data;
                CFG_SCALE_Y: scale_y_next = cfg_data;
                default:     ;
            endcase
        end
    end

    // Saturate the Q8.8-scaled axes, then take magnitudes
    always_comb begin
        psx = px_reg[PROD_W-1:GAIN_FRAC];
        psy = py_reg[PROD_W-1:GAIN_FRAC];
        if (&psx[PROD_W-GAIN_FRAC-1:COORD_WIDTH-1] || ~|psx[PROD_W-GAIN_FRAC-1:COORD_WIDTH-1]) begin
            sx_next = psx[COORD_WIDTH-1:0];
        end else begin
            sx_next = {psx[PROD_W-GAIN_FRAC-1], {(COORD_WIDTH - 1){~psx[PROD_W-GAIN_FRAC-1]}}};
        end
        if (&psy[PROD_W-GAIN_FRAC-1:COORD_WIDTH-1] || ~|psy[PROD_W-GAIN_FRAC-1:COORD_WIDTH-1]) begin
            sy_next = psy[COORD_WIDTH-1:0];
        end else begin
            sy_next = {psy[PROD_W-GAIN_FRAC-1], {(COORD_WIDTH - 1){~psy[PROD_W-GAIN_FRAC-1]}}};
        end
        sxe       = {sx_next[COORD_WIDTH-1], sx_next};
        sye       = {sy_next[COORD_WIDTH-1], sy_next};
        ax_next   = sxe[COORD_WIDTH] ? ABS_W'(-sxe) : ABS_W'(sxe);
        ay_next   = sye[COORD_WIDTH] ? ABS_W'(-sye) : ABS_W'(sye);
        zero_next = (ax_next == '0) && (ay_next == '0);
    end

    // Quadrant placement and rounding to the output resolution
    always_comb begin
        sy_pos = !sy_neg_reg && (ay_reg != '0);
        case ({sx_neg_reg, sy_pos})
            2'b00:   a_q16 = A_W'(t);
            2'b10:   a_q16 = DEG180_Q16 - A_W'(t);
            2'b11:   a_q16 = DEG180_Q16 + A_W'(t);
            default: a_q16 = DEG360_Q16 - A_W'(t);
        endcase
        a_round = (a_q16 + A_W'(ROUND_HALF)) >> ROUND_SH;
    end

    // Wrap a full turn to zero and derive the 8-way direction
    always_comb begin
        ang    = (ang_pre_reg >= ANGLE_FULL) ? (ang_pre_reg - ANGLE_FULL) : ang_pre_reg;
        twice  = {ang, 1'b0};
        q2     = DIR_NUM - twice;
        sector = '0;
        for (int k = 1; k < 8; k++) begin
            if (q2 >= (ANGLE_W + 1)'(k * DIR_DEN)) begin
                sector = 3'(k);
            end
        end
        if (twice > DIR_NUM) begin
            dir_code = DIR_BELOW_RANGE;
        end else if (sector == '0) begin
            dir_code = DIR_SECTOR_ZERO;
        end else begin
            dir_code = DIR_W'(sector);
        end
    end

    // Result assembly; a zero vector repeats the held direction
    always_comb begin
        m_data_next.is_zero   = zero_reg;
        m_data_next.magnitude = zero_reg ? '0 : root;
        m_data_next.angle     = zero_reg ? '0 : ang;
        m_data_next.direction = zero_reg ? last_dir_reg : dir_code;
        last_dir_next         = (out_load && !zero_reg) ? dir_code : last_dir_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MULT;
            ST_MULT:  state_next = ST_CLAMP;
            ST_CLAMP: state_next = zero_next ? ST_OUT : ST_START;
            ST_START: state_next = ST_RUN;
            ST_RUN:   if (cordic_done && isqrt_done) state_next = ST_PLACE;
            ST_PLACE: state_next = ST_OUT;
            ST_OUT:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        unit_start = (state_reg == ST_START);
        out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scale_x_reg  <= GAIN_ONE;
            scale_y_reg  <= GAIN_ONE;
            last_dir_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scale_x_reg  <= scale_x_next;
            scale_y_reg  <= scale_y_next;
            last_dir_reg <= last_dir_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_data.x_in;
            y_reg <= s_data.y_in;
        end
        if (state_reg == ST_MULT) begin
            px_reg <= x_reg * scale_x_reg;
            py_reg <= y_reg * scale_y_reg;
        end
        if (state_reg == ST_CLAMP) begin
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            sx_neg_reg <= sx_next[COORD_WIDTH-1];
            sy_neg_reg <= sy_next[COORD_WIDTH-1];
            zero_reg   <= zero_next;
        end
        if (state_reg == ST_PLACE) begin
            ang_pre_reg <= a_round[ANGLE_W-1:0];
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    // A zero vector reports no length and no angle
    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.is_zero |-> m_data_reg.magnitude == '0 && m_data_reg.angle == '0)
        else $error("zero vector result carries length or angle");

    // A real vector always gets a direction code 1..8
    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.is_zero |->
            m_data_reg.direction != '0 && m_data_reg.direction <= DIR_SECTOR_ZERO)
        else $error("direction code out of range");

    // Angle stays below a full turn
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.angle < ANGLE_FULL)
        else $error("angle not wrapped");

    // A new result only comes out of the output state
    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside the output state");

    // Both units finish before the angle is placed
    a_units_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PLACE |-> cordic_done && isqrt_done)
        else $error("placement before units finished");
`endif

endmodule
